// ===== sv/bcm_pkg.sv =====
`timescale 1ns / 1ps

package bcm_pkg;

	// Field widths
	localparam int COUNT_W  = 20;
	localparam int TARGET_W = 20;
	localparam int DEB_W    = 7;
	localparam int GAP_W    = 17;
	localparam int STALL_W  = 23;
	localparam int MODE_W   = 3;
	localparam int STATE_W  = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	// Queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Limits and timing constants
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
	localparam logic [GAP_W-1:0]    GAP_MAX      = {GAP_W{1'b1}};
	localparam logic [STALL_W-1:0]  STALL_MAX    = {STALL_W{1'b1}};
	localparam logic [STALL_W-1:0]  STALL_LIMIT  = STALL_W'(5000000);
	localparam logic [GAP_W-1:0]    MIN_GAP      = GAP_W'(500);
	localparam logic [GAP_W-1:0]    US_PER_MS    = GAP_W'(1000);
	localparam logic [TARGET_W-1:0] TARGET_MIN   = TARGET_W'(1);
	localparam logic [TARGET_W-1:0] TARGET_MAX   = TARGET_W'(999999);
	localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(120);
	localparam logic [DEB_W-1:0]    DEB_MIN      = DEB_W'(1);
	localparam logic [DEB_W-1:0]    DEB_MAX      = DEB_W'(100);
	localparam logic [GAP_W-1:0]    THRESH_RESET = GAP_W'(5000);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = CFG_IDX_W'(1);

	// Run state codes as seen on the result
	localparam logic [STATE_W-1:0] RS_IDLE    = STATE_W'(0);
	localparam logic [STATE_W-1:0] RS_RUNNING = STATE_W'(1);
	localparam logic [STATE_W-1:0] RS_DONE    = STATE_W'(2);
	localparam logic [STATE_W-1:0] RS_STOPPED = STATE_W'(3);
	localparam logic [STATE_W-1:0] RS_ERROR   = STATE_W'(4);

	// Operator commands
	typedef enum logic [MODE_W-1:0] {
		CMD_NONE  = MODE_W'(0),
		CMD_START = MODE_W'(1),
		CMD_STOP  = MODE_W'(2),
		CMD_CLEAR = MODE_W'(3),
		CMD_ACK   = MODE_W'(4)
	} cmd_t;

	typedef struct packed {
		logic              sensor_edge;
		logic [MODE_W-1:0] mode;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] pulse_count;
		logic [STATE_W-1:0] run_state;
		logic               motor_enable;
		logic               pulse_accepted;
	} out_item_t;

	// Classified tick as it sits in the queue
	typedef struct packed {
		logic sensor_edge;
		cmd_t cmd;
	} tick_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== sv/bcm_front.sv =====
`timescale 1ns / 1ps

module bcm_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  bcm_pkg::in_item_t in_data,
	input  bcm_pkg::queue_stat_t q_stat,
	output logic             push,
	output bcm_pkg::tick_t   tick
);
	import bcm_pkg::*;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;

	// map mode to a command; unknown codes act as no command
	always_comb begin
		tick.sensor_edge = in_data.sensor_edge;
		case (in_data.mode)
			CMD_START: tick.cmd = CMD_START;
			CMD_STOP:  tick.cmd = CMD_STOP;
			CMD_CLEAR: tick.cmd = CMD_CLEAR;
			CMD_ACK:   tick.cmd = CMD_ACK;
			default:   tick.cmd = CMD_NONE;
		endcase
	end

endmodule

// ===== sv/bcm_queue.sv =====
`timescale 1ns / 1ps

module bcm_queue #(
	parameter int DEPTH = bcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bcm_pkg::tick_t       push_data,
	input  logic                 pop,
	output bcm_pkg::tick_t       head,
	output bcm_pkg::queue_stat_t q_stat
);
	import bcm_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	tick_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/bcm_back.sv =====
`timescale 1ns / 1ps

module bcm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	input  bcm_pkg::tick_t                  item,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bcm_pkg::out_item_t              out_data
);
	import bcm_pkg::*;

	typedef enum logic [STATE_W-1:0] {
		S_IDLE    = RS_IDLE,
		S_RUNNING = RS_RUNNING,
		S_DONE    = RS_DONE,
		S_STOPPED = RS_STOPPED,
		S_ERROR   = RS_ERROR
	} state_t;

	state_t              state_q;
	logic                motor_q;
	logic [COUNT_W-1:0]  count_q;
	logic [GAP_W-1:0]    gap_q;
	logic [STALL_W-1:0]  stall_q;
	logic [TARGET_W-1:0] target_q;
	logic [GAP_W-1:0]    thresh_q;
	logic                out_valid_q;
	out_item_t           out_q;

	// configuration, clamped on write
	logic [TARGET_W-1:0] target_wr;
	logic [DEB_W-1:0]    deb_wr;
	logic [GAP_W-1:0]    thresh_wr;

	always_comb begin
		target_wr = cfg_data[TARGET_W-1:0];
		if (target_wr < TARGET_MIN) target_wr = TARGET_MIN;
		if (target_wr > TARGET_MAX) target_wr = TARGET_MAX;
		deb_wr = cfg_data[DEB_W-1:0];
		if (deb_wr < DEB_MIN) deb_wr = DEB_MIN;
		if (deb_wr > DEB_MAX) deb_wr = DEB_MAX;
		thresh_wr = GAP_W'(deb_wr) * US_PER_MS;
		if (thresh_wr < MIN_GAP) thresh_wr = MIN_GAP;
	end

	// one tick of work
	state_t              st_n;
	logic                motor_n;
	logic [COUNT_W-1:0]  count_cmd;
	logic [COUNT_W-1:0]  count_n;
	logic [GAP_W-1:0]    elapsed;
	logic [GAP_W-1:0]    gap_n;
	logic [STALL_W-1:0]  stall_n;
	logic                accept;

	always_comb begin
		st_n      = state_q;
		motor_n   = motor_q;
		count_cmd = count_q;
		stall_n   = (stall_q < STALL_MAX) ? stall_q + 1'b1 : stall_q;

		case (item.cmd)
			CMD_START: begin
				if (state_q != S_ERROR) begin
					if (state_q == S_DONE) count_cmd = '0;
					st_n    = S_RUNNING;
					motor_n = 1'b1;
					stall_n = '0;
				end
			end
			CMD_STOP: begin
				motor_n = 1'b0;
				if (state_q == S_RUNNING) st_n = S_STOPPED;
			end
			CMD_CLEAR: begin
				motor_n   = 1'b0;
				count_cmd = '0;
				st_n      = S_IDLE;
			end
			CMD_ACK: begin
				if (state_q == S_DONE) st_n = S_IDLE;
			end
			default: ;
		endcase

		elapsed = (gap_q < GAP_MAX) ? gap_q + 1'b1 : GAP_MAX;
		accept  = item.sensor_edge && (elapsed >= thresh_q);
		gap_n   = accept ? '0 : elapsed;
		count_n = (accept && count_cmd < COUNT_MAX) ? count_cmd + 1'b1 : count_cmd;

		if (count_n != count_q) stall_n = '0;
		if (st_n == S_RUNNING) begin
			if (count_n >= target_q) begin
				motor_n = 1'b0;
				st_n    = S_DONE;
			end else if (stall_n > STALL_LIMIT) begin
				motor_n = 1'b0;
				st_n    = S_ERROR;
			end
		end
	end

	// take the head when the result slot is free or drains this cycle
	assign pop       = item_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			motor_q     <= 1'b0;
			count_q     <= '0;
			gap_q       <= GAP_MAX;
			stall_q     <= '0;
			target_q    <= TARGET_RESET;
			thresh_q    <= THRESH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET:   target_q <= target_wr;
					CFG_DEBOUNCE: thresh_q <= thresh_wr;
					default: ;
				endcase
			end
			if (pop) begin
				state_q     <= st_n;
				motor_q     <= motor_n;
				count_q     <= count_n;
				gap_q       <= gap_n;
				stall_q     <= stall_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.pulse_count    <= count_n;
			out_q.run_state      <= st_n;
			out_q.motor_enable   <= motor_n;
			out_q.pulse_accepted <= accept;
		end
	end

endmodule

// ===== sv/batch_counter_motor_controller.sv =====
`timescale 1ns / 1ps

// Preset batch counter with motor control. Each request is one microsecond
// tick carrying a raw sensor edge and an optional operator command (start,
// stop, reset, acknowledge); each request yields exactly one result with the
// pulse count, the run state, the motor enable and whether this tick's edge
// passed the debounce spacing of max(500 us, debounce_ms * 1 ms). The block
// takes one request per clock unless out_ready holds it back: a front
// decoder classifies the command, a small queue (QUEUE_DEPTH entries)
// decouples it from the back end, and the back end updates count, timers
// and run state per popped tick and holds the result in an output register.
// A request is held in the queue register, then its result in the output register.
// Configuration writes (target_count at index 0, debounce_ms at index 1)
// take effect at once, are clamped to their legal range, and must be done
// only while no request is in flight.
module batch_counter_motor_controller #(
	parameter int QUEUE_DEPTH = bcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bcm_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bcm_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [bcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bcm_pkg::*;

	queue_stat_t q_stat;
	logic        push;
	logic        pop;
	tick_t       tick_in;
	tick_t       tick_head;

	// classify the command and gate the request against a full queue
	bcm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.tick     (tick_in)
	);

	// hold classified ticks while the result side stalls
	bcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (tick_in),
		.pop       (pop),
		.head      (tick_head),
		.q_stat    (q_stat)
	);

	// advance counter, timers and run state, one tick per pop
	bcm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (!q_stat.empty),
		.item       (tick_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// the motor only runs while the run state says running
	a_motor_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.motor_enable) |-> (out_data.run_state == RS_RUNNING))
		else $error("motor enabled outside running state");

	// a counted edge always leaves a nonzero count
	a_accept_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.pulse_accepted) |-> (out_data.pulse_count != '0))
		else $error("accepted pulse with zero count");

	// a waiting tick moves into a free result slot on the next edge
	a_back_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && !out_valid) |=> out_valid)
		else $error("back end idle while queue holds a tick");

endmodule

// ===== dv/tb_batch_counter_motor_controller.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the preset batch counter. Every request is one
// microsecond tick; every tick yields one reading, so the bench predicts
// each reading when its request is accepted and compares it with the next
// reading that comes out.
module tb_batch_counter_motor_controller;
	import bcm_pkg::*;

	localparam int CYCLE_LIMIT      = 100000;
	localparam int REPORT_LIMIT     = 10;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES    = 4;
	localparam int PHASE_REQUESTS   = 43;

	// Mode codes past the command list; the block must ignore them
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_W'(5);
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = MODE_W'(7);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Shadow of the register file, kept clamped the same way the block clamps
	logic [TARGET_W-1:0] target_setting   = TARGET_RESET;
	logic [DEB_W-1:0]    debounce_setting = DEB_W'(5);

	// Shadow of the controller state as it stands after reset
	logic [COUNT_W-1:0] model_count = '0;
	logic [GAP_W-1:0]   model_gap   = GAP_MAX;
	logic [STALL_W-1:0] model_stall = '0;
	logic [STATE_W-1:0] model_state = RS_IDLE;
	logic               model_motor = 1'b0;

	in_item_t  tick_queue[$];
	out_item_t due_readouts[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int error_count    = 0;
	int cycle_count    = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	batch_counter_motor_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Advance the shadow controller by one tick and return the reading it
	// should produce. Order inside a tick: command, then edge, then the
	// done and stall checks.
	function automatic out_item_t advance_counter(in_item_t t);
		logic [COUNT_W-1:0] prior;
		logic [GAP_W-1:0]   elapsed;
		logic [GAP_W-1:0]   spacing;
		logic               accepted;
		out_item_t          r;
		prior    = model_count;
		accepted = 1'b0;
		if (model_stall != STALL_MAX)
			model_stall = model_stall + 1'b1;

		case (t.mode)
			CMD_START: begin
				// Error is sticky against start; leaving done clears the count
				if (model_state != RS_ERROR) begin
					if (model_state == RS_DONE)
						model_count = '0;
					model_state = RS_RUNNING;
					model_motor = 1'b1;
					model_stall = '0;
				end
			end
			CMD_STOP: begin
				model_motor = 1'b0;
				if (model_state == RS_RUNNING)
					model_state = RS_STOPPED;
			end
			CMD_CLEAR: begin
				// The edge spacing timer is left running on purpose
				model_motor = 1'b0;
				model_count = '0;
				model_state = RS_IDLE;
			end
			CMD_ACK: begin
				if (model_state == RS_DONE)
					model_state = RS_IDLE;
			end
			default: ;
		endcase

		// Edges count in every state, once the spacing has run out
		elapsed = (model_gap != GAP_MAX) ? model_gap + 1'b1 : GAP_MAX;
		spacing = GAP_W'(debounce_setting) * US_PER_MS;
		if (spacing < MIN_GAP)
			spacing = MIN_GAP;
		if (t.sensor_edge && elapsed >= spacing) begin
			accepted  = 1'b1;
			model_gap = '0;
			if (model_count != COUNT_MAX)
				model_count = model_count + 1'b1;
		end else begin
			model_gap = elapsed;
		end

		// A saturated count does not change, so it does not restart the stall timer
		if (model_count != prior)
			model_stall = '0;
		if (model_state == RS_RUNNING) begin
			if (model_count >= target_setting) begin
				model_motor = 1'b0;
				model_state = RS_DONE;
			end else if (model_stall > STALL_LIMIT) begin
				model_motor = 1'b0;
				model_state = RS_ERROR;
			end
		end

		r.pulse_count    = model_count;
		r.run_state      = model_state;
		r.motor_enable   = model_motor;
		r.pulse_accepted = accepted;
		return r;
	endfunction

	// Request driver: predict on acceptance, then offer the next tick unless
	// this cycle is picked as a sender gap.
	always @(posedge clk) begin
		logic taken;
		taken = in_valid && in_ready;
		if (taken)
			due_readouts.push_back(advance_counter(in_data));
		if (!in_valid || taken) begin
			if (arst_n && tick_queue.size() != 0 &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= tick_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked
	// for, so the block backs up and drops in_ready.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= LONG_HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Reading checker: every accepted reading must match the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_readouts.size() == 0) begin
				if (error_count < REPORT_LIMIT)
					$display("unexpected reading: count %0d state %0d motor %0b accepted %0b",
						out_data.pulse_count, out_data.run_state,
						out_data.motor_enable, out_data.pulse_accepted);
				error_count++;
			end else begin
				want = due_readouts.pop_front();
				if (out_data.pulse_count !== want.pulse_count ||
						out_data.run_state !== want.run_state ||
						out_data.motor_enable !== want.motor_enable ||
						out_data.pulse_accepted !== want.pulse_accepted) begin
					if (error_count < REPORT_LIMIT)
						$display("reading mismatch: expected count %0d state %0d",
							want.pulse_count, want.run_state,
							" motor %0b accepted %0b,", want.motor_enable,
							want.pulse_accepted,
							" got count %0d state %0d", out_data.pulse_count,
							out_data.run_state,
							" motor %0b accepted %0b", out_data.motor_enable,
							out_data.pulse_accepted);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("batch_counter_motor_controller test failed");
			$finish;
		end
	end

	task automatic queue_request(logic edge_seen, logic [MODE_W-1:0] mode);
		in_item_t t;
		t.sensor_edge = edge_seen;
		t.mode        = mode;
		tick_queue.push_back(t);
	endtask

	// Push quiet ticks: no edge, no command
	task automatic queue_quiet(int ticks);
		repeat (ticks) queue_request(1'b0, CMD_NONE);
	endtask

	// One random request. Most are edges after a short bounce gap; the rest
	// are commands, spare mode codes included, each with a random edge bit.
	task automatic queue_random_request();
		int unsigned pick;
		logic        edge_seen;
		pick      = $urandom_range(99, 0);
		edge_seen = 1'($urandom_range(1, 0));
		if (pick < 58) begin
			queue_quiet(int'($urandom_range(2, 0)));
			queue_request(1'b1, CMD_NONE);
		end else if (pick < 74) begin
			queue_request(edge_seen, CMD_START);
		end else if (pick < 82) begin
			queue_request(edge_seen, CMD_STOP);
		end else if (pick < 87) begin
			queue_request(edge_seen, CMD_CLEAR);
		end else if (pick < 95) begin
			queue_request(edge_seen, CMD_ACK);
		end else begin
			queue_request(edge_seen,
				MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST)));
		end
	endtask

	// Wait until every tick is accepted and every reading has come back.
	// Sample on the falling edge so the driver's updates have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (tick_queue.size() != 0 || in_valid || due_readouts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register and clamp the shadow copy to its legal range
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		logic [DEB_W-1:0] deb;
		deb = value[DEB_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TARGET) begin
			if (value < TARGET_MIN)
				target_setting = TARGET_MIN;
			else if (value > TARGET_MAX)
				target_setting = TARGET_MAX;
			else
				target_setting = value;
		end else begin
			if (deb < DEB_MIN)
				debounce_setting = DEB_MIN;
			else if (deb > DEB_MAX)
				debounce_setting = DEB_MAX;
			else
				debounce_setting = deb;
		end
	endtask

	// Drain, reconfigure, set the idling mix and queue a batch of random requests
	task automatic run_phase(int send_pct, int stall_pct, logic [CFG_DATA_W-1:0] target_value,
			logic [CFG_DATA_W-1:0] debounce_value, bit long_hold);
		wait_drained();
		write_register(CFG_TARGET, target_value);
		write_register(CFG_DEBOUNCE, debounce_value);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		if (long_hold)
			hold_requests++;
		repeat (PHASE_REQUESTS) queue_random_request();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: target 120, 5 ms spacing
		queue_request(1'b0, CMD_NONE);          // quiet tick, spacing timer still saturated
		queue_request(1'b1, CMD_NONE);          // first edge after reset counts, even in idle
		queue_request(1'b1, CMD_NONE);          // bounce right after, dropped
		queue_request(1'b0, MODE_SPARE_FIRST);  // spare mode codes do nothing
		queue_request(1'b1, MODE_SPARE_LAST);
		queue_request(1'b0, CMD_ACK);           // acknowledge outside done is ignored
		queue_request(1'b0, CMD_STOP);          // stop in idle keeps idle
		queue_request(1'b0, CMD_START);         // idle to running, motor on
		queue_request(1'b1, CMD_START);         // start while running restarts the stall timer
		queue_request(1'b0, CMD_STOP);          // running to stopped
		queue_request(1'b0, CMD_START);         // stopped back to running
		queue_request(1'b0, CMD_CLEAR);         // clear drops to idle with count zero
		wait_drained();

		// Target of one and the shortest spacing to walk the whole run cycle.
		// Fill quiet ticks so the next tick lands one short of the spacing.
		write_register(CFG_TARGET, CFG_DATA_W'(1));
		write_register(CFG_DEBOUNCE, CFG_DATA_W'(1));
		queue_quiet(int'(US_PER_MS) - 2 - int'(model_gap));
		queue_request(1'b1, CMD_START);         // idle to running, edge one tick short
		queue_request(1'b1, CMD_NONE);          // exactly on the spacing, reaches target
		queue_request(1'b0, CMD_STOP);          // stop in done keeps done, motor off
		queue_request(1'b0, CMD_ACK);           // done to idle, count kept
		queue_request(1'b0, CMD_START);         // count already at target: done at once
		queue_request(1'b1, CMD_START);         // leave done: count cleared, edge too early
		queue_request(1'b0, CMD_STOP);          // running to stopped
		queue_request(1'b1, CMD_CLEAR);         // clear to idle, bounce dropped
		wait_drained();

		// Longest spacing, written out of range so it clamps to 100 ms
		write_register(CFG_DEBOUNCE, CFG_DATA_W'(DEB_W'('1)));
		queue_request(1'b1, CMD_NONE);          // far too early, dropped

		// Random phases. Walk the idling mixes twice with different settings,
		// extremes and clamped writes among them. The stall limit of five
		// seconds of ticks lies beyond the length of this run.
		run_phase(0, 0, CFG_DATA_W'(0), CFG_DATA_W'(0), 1'b1);
		run_phase(53, 0, CFG_DATA_W'(3), CFG_DATA_W'(20'hFFF81), 1'b0);
		run_phase(0, 53, CFG_DATA_W'(5), CFG_DATA_W'(2), 1'b0);
		run_phase(7, 7, CFG_DATA_W'('1), CFG_DATA_W'(1), 1'b1);
		run_phase(0, 0, CFG_DATA_W'($urandom_range(4, 1)), CFG_DATA_W'(1), 1'b0);
		run_phase(53, 0, CFG_DATA_W'(2), CFG_DATA_W'(1), 1'b0);
		run_phase(0, 53, CFG_DATA_W'(1), CFG_DATA_W'(1), 1'b0);
		run_phase(7, 7, CFG_DATA_W'(4), CFG_DATA_W'(1), 1'b1);
		wait_drained();

		if (error_count == 0)
			$display("batch_counter_motor_controller test passed");
		else
			$display("batch_counter_motor_controller test failed");
		$finish;
	end

endmodule
